// ----- sv/assert_macros.svh -----
// Assertion helpers used by the classifier top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   `ASSERT_SYNC(label, clk, rst, !(cond), msg)

`endif

// ----- sv/pfc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, register indexes and reset values for the particulate fan-level
// classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

   localparam int SampleWidth  = 16;
   localparam int HoldWidth    = 8;
   localparam int LimitWidth   = 4;
   localparam int LevelWidth   = 2;
   localparam int CsrIdxWidth  = 2;
   localparam int CsrDataWidth = 16;
   localparam int ReqDataWidth = 24;
   localparam int RspDataWidth = 8;

   typedef logic [SampleWidth-1:0] sample_type;
   typedef logic [LevelWidth-1:0]  level_type;
   typedef logic [HoldWidth-1:0]   hold_type;

   // Request kind carried in tuser
   typedef enum logic {
      FUNC_TICK  = 1'b0,
      FUNC_SMART = 1'b1
   } func_type;

   // Configuration register indexes
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_TICK_PERIOD    = 2'd0,
      CSR_HIGH_THRESHOLD = 2'd1,
      CSR_LOW_THRESHOLD  = 2'd2,
      CSR_HOLD_LIMIT     = 2'd3
   } csr_idx_type;

   // Air classes
   localparam level_type LEVEL_NONE = 2'd0;
   localparam level_type LEVEL_LOW  = 2'd1;
   localparam level_type LEVEL_MED  = 2'd2;
   localparam level_type LEVEL_HIGH = 2'd3;

   // Reset values
   localparam sample_type TICK_PERIOD_RST = 16'd50000;
   localparam sample_type HIGH_THRESH_RST = 16'd200;
   localparam sample_type LOW_THRESH_RST  = 16'd100;
   localparam logic [LimitWidth-1:0] HOLD_LIMIT_RST = 4'd4;

   // Marks that the last evaluation was a normal classification
   localparam hold_type HOLD_DONE = 8'hFF;

   // Plain threshold classification, no hysteresis
   function automatic level_type classify_plain(sample_type s, sample_type hi,
                                                sample_type lo);
      level_type lvl;
      if (s > hi) begin
         lvl = LEVEL_HIGH;
      end else if (s > lo) begin
         lvl = LEVEL_MED;
      end else begin
         lvl = LEVEL_LOW;
      end
      return lvl;
   endfunction

endpackage

`default_nettype wire

// ----- sv/pm25_fan_level_classifier_top.sv -----
// ----------------------------------------------------------------------------
// pm25_fan_level_classifier_top
// Classifies particulate samples into air class 1..3 with hysteresis and a
// falling-reading hold, and reports the fan / LED drive level on a change of class or when smart mode is switched on.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser = func (0 tick with sample, 1 smart mode command),
//     tdata = sample in [15:0], mode_on in [16]. rsp channel: tdata [1:0]
//     holds drive_level (1 low / blue, 2 medium / yellow, 3 high / red).
//   csr port: csr_wr_en writes csr_wdata into the register at csr_index
//     (0 tick_period, 1 high_threshold, 2 low_threshold, 3 hold_limit).
//   A request is captured into an input register, then evaluated against the
//   class state; a drive result lands in the response register. rsp_tvalid
//   rises after the request has passed the input and response registers.
//   Throughput is one request per cycle while no result waits on rsp_tready,
//   set by the state update of the class and counter registers.
//   Most requests give no result: ticks while smart mode is off, ticks
//   between evaluations, and evaluations that keep the class.
//   When rsp_tready is low with a result pending, one more request is held
//   in the input register; after that req_tready drops.
//   Reset clears smart mode, counters and class state and loads the
//   register reset values; no result is pending after reset.
`default_nettype none

module pm25_fan_level_classifier_top (
   input  wire  logic                               clock,
   input  wire  logic                               reset,
   // request stream
   input  wire  logic                               req_tvalid,
   output       logic                               req_tready,
   input  wire  logic [pfc_pkg::ReqDataWidth-1:0]   req_tdata,  // sample, mode_on
   input  wire  logic                               req_tuser,  // func
   // response stream
   output       logic                               rsp_tvalid,
   input  wire  logic                               rsp_tready,
   output       logic [pfc_pkg::RspDataWidth-1:0]   rsp_tdata,  // drive_level
   // configuration write port
   input  wire  logic                               csr_wr_en,
   input  wire  logic [pfc_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire  logic [pfc_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import pfc_pkg::*;

   `include "assert_macros.svh"

   // configuration registers
   sample_type              tick_period_ff;
   sample_type              high_thresh_ff;
   sample_type              low_thresh_ff;
   logic [LimitWidth-1:0]   hold_limit_ff;

   // input register
   logic                    in_valid_ff;
   func_type                in_func_ff;
   sample_type              in_sample_ff;
   logic                    in_mode_ff;

   // class state
   logic                    smart_ff,        smart_in;
   sample_type              tick_count_ff,   tick_count_in;
   hold_type                hold_count_ff,   hold_count_in;
   level_type               class_before_ff, class_before_in;
   level_type               air_class_ff,    air_class_in;
   sample_type              held_sample_ff,  held_sample_in;
   sample_type              last_sample_ff,  last_sample_in;

   // response register
   logic                    rsp_valid_ff;
   level_type               rsp_level_ff;

   logic                    proc_go;
   logic                    emit;
   level_type               emit_level;

   // intermediate evaluation terms
   sample_type              tick_next;
   logic                    falls_old;
   logic                    falls_new;
   logic                    hold_path;
   level_type               new_class;

   assign proc_go    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc_go;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-LevelWidth){1'b0}}, rsp_level_ff};

   // evaluate one request against the class state
   always_comb begin
      smart_in        = smart_ff;
      tick_count_in   = tick_count_ff;
      hold_count_in   = hold_count_ff;
      class_before_in = class_before_ff;
      air_class_in    = air_class_ff;
      held_sample_in  = held_sample_ff;
      last_sample_in  = last_sample_ff;
      emit            = 1'b0;
      emit_level      = classify_plain(in_sample_ff, high_thresh_ff, low_thresh_ff);

      tick_next = tick_count_ff + 16'd1;
      falls_old = (class_before_ff == LEVEL_HIGH && air_class_ff == LEVEL_MED) ||
                  (held_sample_ff < last_sample_ff);
      falls_new = (class_before_ff == LEVEL_HIGH && air_class_ff == LEVEL_MED) ||
                  (in_sample_ff < last_sample_ff);
      hold_path = falls_old && (hold_count_ff < {{(HoldWidth-LimitWidth){1'b0}},
                                                 hold_limit_ff});

      // hysteresis classification of the new sample
      if (in_sample_ff > high_thresh_ff) begin
         new_class = (last_sample_ff <= low_thresh_ff) ? LEVEL_MED : LEVEL_HIGH;
      end else if (in_sample_ff > low_thresh_ff) begin
         new_class = LEVEL_MED;
      end else begin
         new_class = (last_sample_ff > high_thresh_ff) ? LEVEL_MED : LEVEL_LOW;
      end

      if (proc_go) begin
         if (in_func_ff == FUNC_SMART) begin
            // smart mode command: on reports the plain level at once
            smart_in = in_mode_ff;
            emit     = in_mode_ff;
         end else if (smart_ff) begin
            // prescaler
            if (tick_next < tick_period_ff) begin
               tick_count_in = tick_next;
            end else begin
               tick_count_in  = '0;
               held_sample_in = in_sample_ff;
               if (hold_path && (in_sample_ff < last_sample_ff)) begin
                  // keep holding the old class
                  hold_count_in = hold_count_ff + 8'd1;
               end else if (!hold_path && falls_new && hold_count_ff == HOLD_DONE &&
                            air_class_ff > LEVEL_LOW) begin
                  // start a hold
                  hold_count_in = '0;
               end else begin
                  class_before_in = air_class_ff;
                  air_class_in    = new_class;
                  last_sample_in  = in_sample_ff;
                  hold_count_in   = HOLD_DONE;
                  emit            = (air_class_ff != new_class);
                  emit_level      = new_class;
               end
            end
         end
      end
   end

   // hold configuration, input, state and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff  <= TICK_PERIOD_RST;
         high_thresh_ff  <= HIGH_THRESH_RST;
         low_thresh_ff   <= LOW_THRESH_RST;
         hold_limit_ff   <= HOLD_LIMIT_RST;
         in_valid_ff     <= 1'b0;
         smart_ff        <= 1'b0;
         tick_count_ff   <= '0;
         hold_count_ff   <= '0;
         class_before_ff <= LEVEL_NONE;
         air_class_ff    <= LEVEL_NONE;
         held_sample_ff  <= '0;
         last_sample_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_idx_type'(csr_index))
               CSR_TICK_PERIOD:    tick_period_ff <= csr_wdata;
               CSR_HIGH_THRESHOLD: high_thresh_ff <= csr_wdata;
               CSR_LOW_THRESHOLD:  low_thresh_ff  <= csr_wdata;
               CSR_HOLD_LIMIT:     hold_limit_ff  <= csr_wdata[LimitWidth-1:0];
               default: begin
               end
            endcase
         end

         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end

         smart_ff        <= smart_in;
         tick_count_ff   <= tick_count_in;
         hold_count_ff   <= hold_count_in;
         class_before_ff <= class_before_in;
         air_class_ff    <= air_class_in;
         held_sample_ff  <= held_sample_in;
         last_sample_ff  <= last_sample_in;

         if (proc_go) begin
            rsp_valid_ff <= emit;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // capture request payload and response level
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_func_ff   <= func_type'(req_tuser);
         in_sample_ff <= req_tdata[SampleWidth-1:0];
         in_mode_ff   <= req_tdata[SampleWidth];
      end
      if (proc_go && emit) begin
         rsp_level_ff <= emit_level;
      end
   end

   `ASSERT_NEVER(a_level_nonzero, clock, reset, rsp_valid_ff && rsp_level_ff == LEVEL_NONE, "result with no class")
   `ASSERT_SYNC(a_rsp_from_item, clock, reset, $rose(rsp_valid_ff) |-> $past(proc_go), "result without a processed request")
   `ASSERT_SYNC(a_done_has_class, clock, reset, (hold_count_ff == HOLD_DONE) |-> (air_class_ff != LEVEL_NONE), "classified state with no class")
   `ASSERT_SYNC(a_off_no_count, clock, reset, (proc_go && in_func_ff == FUNC_TICK && !smart_ff) |=> $stable(tick_count_ff), "prescaler moved in manual mode")

endmodule

`default_nettype wire
